@@ rtl/dma_ring_pointer_device_assert.svh @@
// ----------------------------------------------------------------------------
// dma ring pointer device assertion macros
// clocked assertion wrappers used by dma_ring_pointer_device, compiled out by ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef DMA_RING_POINTER_DEVICE_ASSERT_SVH
`define DMA_RING_POINTER_DEVICE_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define DRPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("drpd assertion failed");

// condition must never be seen outside reset
`define DRPD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `DRPD_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define DRPD_ASSERT(lbl, clk, rst_n, prop)
`define DRPD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/drpd_pkg.sv @@
// ----------------------------------------------------------------------------
// drpd_pkg
// types, codes and register map of the dma ring pointer device
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package drpd_pkg;

    // bytes in one ring slot
    localparam int unsigned FRAME_BYTES = 4096;

    // operation codes
    localparam logic [2:0] OP_BUS_READ  = 3'd0;
    localparam logic [2:0] OP_BUS_WRITE = 3'd1;
    localparam logic [2:0] OP_RX_FRAME  = 3'd2;
    localparam logic [2:0] OP_TX_FRAME  = 3'd3;
    localparam logic [2:0] OP_IRQ_TICK  = 3'd4;

    // register map
    localparam logic [15:0] ADDR_ID        = 16'h0000;
    localparam logic [15:0] ADDR_MAGIC     = 16'h0004;
    localparam logic [15:0] ADDR_TEMP      = 16'h0010;
    localparam logic [15:0] ADDR_CLOCK     = 16'h0020;
    localparam logic [15:0] ADDR_PORT1     = 16'h0100;
    localparam logic [15:0] ADDR_PORT2     = 16'h0200;
    localparam logic [15:0] ADDR_RX_START  = 16'h08A0;
    localparam logic [15:0] ADDR_RX_END    = 16'h08A4;
    localparam logic [15:0] ADDR_RX_RDPTR  = 16'h08A8;
    localparam logic [15:0] ADDR_TX_START  = 16'h08C0;
    localparam logic [15:0] ADDR_TX_END    = 16'h08C4;
    localparam logic [15:0] ADDR_TX_WRPTR  = 16'h08CC;
    localparam logic [15:0] ADDR_RX_WRPTR  = 16'h0A0C;
    localparam logic [15:0] ADDR_TX_RDPTR  = 16'h0B08;
    localparam logic [15:0] ADDR_LINK1     = 16'h9000;
    localparam logic [15:0] ADDR_LINK2     = 16'hB000;

    // fixed read values
    localparam logic [31:0] ID_WORD        = 32'h22010de5;
    localparam logic [31:0] MAGIC_WORD     = 32'hdeadbeef;
    localparam logic [31:0] CLOCK_WORD     = 32'd106249998;
    localparam logic [31:0] PORT_UP_WORD   = 32'h1;
    localparam logic [31:0] PORT_DOWN_WORD = 32'hb;
    localparam logic [31:0] LINK_DOWN_WORD = 32'h7;

    localparam logic [8:0]  TEMP_RESET     = 9'd434;
    localparam int unsigned PORT_OFF_BIT   = 3;
    localparam logic [3:0]  META_FLAGS     = 4'h4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] bus_address;
        logic        access_is_word;
        logic [31:0] write_data;
        logic [1:0]  frame_port;
        logic [9:0]  frame_words;
        logic [15:0] tx_metadata;
    } drpd_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        frame_written;
        logic [31:0] meta_address;
        logic [15:0] rx_metadata;
        logic        frame_committed;
        logic        overflow_irq;
        logic        rx_irq;
        logic [31:0] payload_read_address;
        logic [9:0]  payload_words;
        logic        tx_taken;
    } drpd_result_t;

endpackage

@@ rtl/drpd_ring_advance.sv @@
// ----------------------------------------------------------------------------
// drpd_ring_advance
// steps a ring pointer by one slot, wrapping from the ring end to the start
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drpd_ring_advance
    import drpd_pkg::*;
(
    input  logic [31:0] ring_start,
    input  logic [31:0] ring_stop,
    input  logic [31:0] ptr,
    output logic [31:0] next_ptr
);

    logic [32:0] stepped;
    logic [32:0] overshoot;

    // carry kept so the compare against the end sees the true sum
    assign stepped   = {1'b0, ptr} + 33'(FRAME_BYTES);
    assign overshoot = stepped - {1'b0, ring_stop};

    always_comb
    begin
        if ({1'b0, ring_stop} > stepped)
        begin
            next_ptr = stepped[31:0];
        end
        else
        begin
            next_ptr = ring_start + overshoot[31:0];
        end
    end

endmodule

@@ rtl/dma_ring_pointer_device.sv @@
// a beat accepted into the stage 1 register has its result registered in the result register once the output is free
// throughput: one beat per cycle in both directions while out_stall is low
// the input register and the result register each take a new beat every cycle while out_stall is low
// reset (rst_n low, asynchronous) clears all ring pointers, enables and irq arm
// temperature register resets to 434; payload registers are not reset
// ----------------------------------------------------------------------------
// dma_ring_pointer_device
// register window and rx/tx frame ring pointer engine of a two-port card
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dma_ring_pointer_device_assert.svh"

module dma_ring_pointer_device
    import drpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,

    // input beat channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [15:0] bus_address,
    input  logic        access_is_word,
    input  logic [31:0] write_data,
    input  logic [1:0]  frame_port,
    input  logic [9:0]  frame_words,
    input  logic [15:0] tx_metadata,

    // result beat channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        frame_written,
    output logic [31:0] meta_address,
    output logic [15:0] rx_metadata,
    output logic        frame_committed,
    output logic        overflow_irq,
    output logic        rx_irq,
    output logic [31:0] payload_read_address,
    output logic [9:0]  payload_words,
    output logic        tx_taken
);

    // ------------------------------------------------------------------
    // pipeline control
    // stage 1 holds the accepted beat; its work runs against the ring
    // state and lands in the result register together with the state update
    // ------------------------------------------------------------------
    logic         s1_valid_reg;
    drpd_item_t   s1_item_reg;
    logic         out_valid_reg;
    drpd_result_t out_reg;
    drpd_result_t out_next;

    logic         out_free;
    logic         s1_fire;
    logic         in_fire;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // ring state
    // ------------------------------------------------------------------
    logic [8:0]  temp_code_reg;
    logic [31:0] rx_start_reg,  rx_start_next;
    logic [31:0] rx_end_reg,    rx_end_next;
    logic [31:0] rx_rdptr_reg,  rx_rdptr_next;
    logic [31:0] rx_wrptr_reg,  rx_wrptr_next;
    logic [31:0] tx_start_reg,  tx_start_next;
    logic [31:0] tx_end_reg,    tx_end_next;
    logic [31:0] tx_rdptr_reg,  tx_rdptr_next;
    logic [31:0] tx_wrptr_reg,  tx_wrptr_next;
    logic        irq_armed_reg, irq_armed_next;
    logic [1:0]  port_en_reg,   port_en_next;

    // pointer steppers for both rings
    logic [31:0] rx_wrptr_step;
    logic [31:0] tx_rdptr_step;

    drpd_ring_advance u_rx_advance (
        .ring_start (rx_start_reg),
        .ring_stop  (rx_end_reg),
        .ptr        (rx_wrptr_reg),
        .next_ptr   (rx_wrptr_step)
    );

    drpd_ring_advance u_tx_advance (
        .ring_start (tx_start_reg),
        .ring_stop  (tx_end_reg),
        .ptr        (tx_rdptr_reg),
        .next_ptr   (tx_rdptr_step)
    );

    // ------------------------------------------------------------------
    // beat decode
    // ------------------------------------------------------------------
    logic        op_read;
    logic        op_write;
    logic        op_rx;
    logic        op_tx;
    logic        op_tick;
    logic        tx_go;
    logic        put_go;
    logic        rx_full;
    logic [1:0]  put_port;
    logic [9:0]  put_words;
    logic [31:0] rd_word;

    assign op_read  = s1_item_reg.operation == OP_BUS_READ;
    assign op_write = s1_item_reg.operation == OP_BUS_WRITE;
    assign op_rx    = s1_item_reg.operation == OP_RX_FRAME;
    assign op_tx    = s1_item_reg.operation == OP_TX_FRAME;
    assign op_tick  = s1_item_reg.operation == OP_IRQ_TICK;

    // tx slot present; a looped-back frame goes in even on an unset rx ring
    assign tx_go  = op_tx && (tx_rdptr_reg != tx_wrptr_reg);
    assign put_go = (op_rx && (rx_start_reg != rx_end_reg)) || tx_go;

    // one slot ahead landing on the reader means full
    assign rx_full = rx_wrptr_step == rx_rdptr_reg;

    assign put_port  = op_tx ? s1_item_reg.tx_metadata[15:14] : s1_item_reg.frame_port;
    assign put_words = op_tx ? s1_item_reg.tx_metadata[13:4]  : s1_item_reg.frame_words;

    // register window read mux
    always_comb
    begin
        unique case (s1_item_reg.bus_address)
            ADDR_ID:       rd_word = ID_WORD;
            ADDR_MAGIC:    rd_word = MAGIC_WORD;
            ADDR_TEMP:     rd_word = {23'd0, temp_code_reg};
            ADDR_CLOCK:    rd_word = CLOCK_WORD;
            ADDR_PORT1:    rd_word = port_en_reg[0] ? PORT_UP_WORD : PORT_DOWN_WORD;
            ADDR_PORT2:    rd_word = port_en_reg[1] ? PORT_UP_WORD : PORT_DOWN_WORD;
            ADDR_RX_WRPTR: rd_word = rx_wrptr_reg;
            ADDR_TX_RDPTR: rd_word = tx_rdptr_reg;
            ADDR_LINK1:    rd_word = port_en_reg[0] ? 32'd0 : LINK_DOWN_WORD;
            ADDR_LINK2:    rd_word = port_en_reg[1] ? PORT_UP_WORD : LINK_DOWN_WORD;
            default:       rd_word = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // next state and result
    // ------------------------------------------------------------------
    always_comb
    begin
        rx_start_next  = rx_start_reg;
        rx_end_next    = rx_end_reg;
        rx_rdptr_next  = rx_rdptr_reg;
        rx_wrptr_next  = rx_wrptr_reg;
        tx_start_next  = tx_start_reg;
        tx_end_next    = tx_end_reg;
        tx_rdptr_next  = tx_rdptr_reg;
        tx_wrptr_next  = tx_wrptr_reg;
        irq_armed_next = irq_armed_reg;
        port_en_next   = port_en_reg;
        out_next       = '0;

        // bus reads; non-word accesses read zero
        if (op_read && s1_item_reg.access_is_word)
        begin
            out_next.read_data = rd_word;
        end

        // bus writes; non-word accesses are dropped
        if (op_write && s1_item_reg.access_is_word)
        begin
            unique case (s1_item_reg.bus_address)
                ADDR_PORT1:
                begin
                    port_en_next[0] = !s1_item_reg.write_data[PORT_OFF_BIT];
                end
                ADDR_PORT2:
                begin
                    port_en_next[1] = !s1_item_reg.write_data[PORT_OFF_BIT];
                end
                ADDR_RX_START:
                begin
                    rx_start_next = s1_item_reg.write_data;
                    rx_end_next   = s1_item_reg.write_data;
                    rx_rdptr_next = s1_item_reg.write_data;
                    rx_wrptr_next = s1_item_reg.write_data;
                end
                ADDR_RX_END:
                begin
                    rx_end_next = s1_item_reg.write_data;
                end
                ADDR_RX_RDPTR:
                begin
                    rx_rdptr_next  = s1_item_reg.write_data;
                    irq_armed_next = 1'b1;
                end
                ADDR_TX_START:
                begin
                    tx_start_next = s1_item_reg.write_data;
                    tx_end_next   = s1_item_reg.write_data;
                    tx_rdptr_next = s1_item_reg.write_data;
                    tx_wrptr_next = s1_item_reg.write_data;
                end
                ADDR_TX_END:
                begin
                    tx_end_next = s1_item_reg.write_data;
                end
                ADDR_TX_WRPTR:
                begin
                    tx_wrptr_next = s1_item_reg.write_data;
                end
                default:
                begin
                end
            endcase
        end

        // frame into the rx ring, from the wire or looped back from tx
        if (put_go)
        begin
            out_next.frame_written = 1'b1;
            out_next.meta_address  = rx_wrptr_reg;
            out_next.rx_metadata   = {put_port, put_words, META_FLAGS};
            if (rx_full)
            begin
                out_next.overflow_irq = 1'b1;
            end
            else
            begin
                out_next.frame_committed = 1'b1;
                rx_wrptr_next            = rx_wrptr_step;
            end
        end

        // tx slot consumed
        if (tx_go)
        begin
            out_next.payload_read_address =
                tx_rdptr_reg + {28'd0, s1_item_reg.tx_metadata[3:0]};
            out_next.payload_words = s1_item_reg.tx_metadata[13:4];
            out_next.tx_taken      = 1'b1;
            tx_rdptr_next          = tx_rdptr_step;
        end

        // one interrupt per re-arm while the rx ring holds data
        if (op_tick && irq_armed_reg && (rx_rdptr_reg != rx_wrptr_reg))
        begin
            out_next.rx_irq = 1'b1;
            irq_armed_next  = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            temp_code_reg <= TEMP_RESET;
            rx_start_reg  <= '0;
            rx_end_reg    <= '0;
            rx_rdptr_reg  <= '0;
            rx_wrptr_reg  <= '0;
            tx_start_reg  <= '0;
            tx_end_reg    <= '0;
            tx_rdptr_reg  <= '0;
            tx_wrptr_reg  <= '0;
            irq_armed_reg <= 1'b0;
            port_en_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                temp_code_reg <= cfg_wdata;
            end

            // stage 1 refills as it drains
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // state moves only when the beat's result is taken into the output
            if (s1_fire)
            begin
                rx_start_reg  <= rx_start_next;
                rx_end_reg    <= rx_end_next;
                rx_rdptr_reg  <= rx_rdptr_next;
                rx_wrptr_reg  <= rx_wrptr_next;
                tx_start_reg  <= tx_start_next;
                tx_end_reg    <= tx_end_next;
                tx_rdptr_reg  <= tx_rdptr_next;
                tx_wrptr_reg  <= tx_wrptr_next;
                irq_armed_reg <= irq_armed_next;
                port_en_reg   <= port_en_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.operation      <= operation;
            s1_item_reg.bus_address    <= bus_address;
            s1_item_reg.access_is_word <= access_is_word;
            s1_item_reg.write_data     <= write_data;
            s1_item_reg.frame_port     <= frame_port;
            s1_item_reg.frame_words    <= frame_words;
            s1_item_reg.tx_metadata    <= tx_metadata;
        end
        if (s1_fire)
        begin
            out_reg <= out_next;
        end
    end

    // ------------------------------------------------------------------
    // result beat
    // ------------------------------------------------------------------
    assign out_valid            = out_valid_reg;
    assign read_data            = out_reg.read_data;
    assign frame_written        = out_reg.frame_written;
    assign meta_address         = out_reg.meta_address;
    assign rx_metadata          = out_reg.rx_metadata;
    assign frame_committed      = out_reg.frame_committed;
    assign overflow_irq         = out_reg.overflow_irq;
    assign rx_irq               = out_reg.rx_irq;
    assign payload_read_address = out_reg.payload_read_address;
    assign payload_words        = out_reg.payload_words;
    assign tx_taken             = out_reg.tx_taken;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `DRPD_ASSERT_NEVER(a_commit_xor_overflow, clk, rst_n,
        out_valid_reg && out_reg.frame_committed && out_reg.overflow_irq)
    `DRPD_ASSERT(a_commit_needs_write, clk, rst_n,
        (out_valid_reg && out_reg.frame_committed) |-> out_reg.frame_written)
    `DRPD_ASSERT(a_tx_loops_back, clk, rst_n,
        (out_valid_reg && out_reg.tx_taken) |-> out_reg.frame_written)
    `DRPD_ASSERT(a_irq_disarms, clk, rst_n,
        (out_valid_reg && out_reg.rx_irq) |-> !irq_armed_reg)
    `DRPD_ASSERT(a_stall_only_when_full, clk, rst_n,
        in_stall |-> (s1_valid_reg && out_valid_reg))

endmodule
